// File: sv/qps_pkg.sv
// Shared types and constants for the quadrature position and speed block.
// No dependencies; every other file imports this package.
package qps_pkg;

    localparam int TIME_WIDTH = 24;
    localparam int ELAPSED_W  = 24;
    localparam int EFF_TIME_W = (TIME_WIDTH < ELAPSED_W) ? TIME_WIDTH : ELAPSED_W;
    localparam int PPR_W      = 16;
    localparam int POS_W      = 32;
    localparam int K_W        = 26;
    localparam logic [K_W-1:0] US_PER_MIN = K_W'(60000000);
    localparam int PROD_W     = POS_W + K_W;
    localparam int DEN_W      = PPR_W + EFF_TIME_W;
    localparam int REM_W      = DEN_W + 1;
    localparam int CNT_W      = $clog2(PROD_W);
    localparam logic [PPR_W-1:0] PPR_RESET = PPR_W'(20);

    typedef enum logic [1:0] {
        OP_EDGE_A = 2'd0,
        OP_EDGE_B = 2'd1,
        OP_SPEED  = 2'd2,
        OP_ZERO   = 2'd3
    } t_op;

    typedef struct packed {
        logic accept;    // take the input item
        logic mul;       // form magnitude product and divisor
        logic div_step;  // one restoring division step
        logic finish;    // write speed and clip flag
    } t_dp_cmd;

    typedef struct packed {
        logic denom_zero;
    } t_dp_sts;

endpackage

// File: sv/qps_datapath.sv
// Datapath: position counters, speed multiplier, bit-serial divider, result state.
// Depends on qps_pkg; driven by qps_ctrl through t_dp_cmd.
module qps_datapath import qps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  t_op                   i_op,
    input  logic                  i_level_a,
    input  logic                  i_level_b,
    input  logic [ELAPSED_W-1:0]  i_elapsed_us,
    input  logic                  i_cfg_we,
    input  logic [PPR_W-1:0]      i_cfg_data,
    output logic [POS_W-1:0]      o_position,
    output logic [POS_W-1:0]      o_speed_rpm,
    output logic                  o_speed_saturated
);

    logic [PPR_W-1:0]      r_ppr;
    logic [POS_W-1:0]      r_pulse, n_pulse;
    logic [POS_W-1:0]      r_last;
    logic [POS_W-1:0]      r_diff;
    logic [EFF_TIME_W-1:0] r_elapsed;
    logic                  r_neg;
    logic [PROD_W-1:0]     r_dvd;
    logic [DEN_W-1:0]      r_den;
    logic [REM_W-1:0]      r_rem;
    logic [POS_W-1:0]      r_speed;
    logic                  r_clip;

    logic [POS_W-1:0]      mag;
    logic [REM_W-1:0]      rem_sh;
    logic                  fits;
    logic                  sat_pos;
    logic                  sat_neg;

    always_comb begin
        unique case (i_op)
            OP_EDGE_A: n_pulse = (i_level_a == i_level_b) ? r_pulse + 1'b1 : r_pulse - 1'b1;
            OP_EDGE_B: n_pulse = (i_level_a != i_level_b) ? r_pulse + 1'b1 : r_pulse - 1'b1;
            OP_ZERO:   n_pulse = '0;
            default:   n_pulse = r_pulse;
        endcase
    end

    // The most negative difference negates to itself, which is the wanted magnitude.
    assign mag    = r_diff[POS_W-1] ? (~r_diff + 1'b1) : r_diff;
    assign rem_sh = {r_rem[DEN_W-1:0], r_dvd[PROD_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    assign sat_pos = |r_dvd[PROD_W-1:POS_W-1];
    assign sat_neg = (|r_dvd[PROD_W-1:POS_W]) ||
                     (r_dvd[POS_W-1] && (|r_dvd[POS_W-2:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr   <= PPR_RESET;
            r_pulse <= '0;
            r_last  <= '0;
            r_speed <= '0;
            r_clip  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ppr <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_pulse <= n_pulse;
                if (i_op == OP_SPEED) begin
                    r_last <= r_pulse;
                end else if (i_op == OP_ZERO) begin
                    r_last <= '0;
                end
            end
            if (i_cmd.finish) begin
                if (r_den == '0) begin
                    r_speed <= '0;
                    r_clip  <= 1'b0;
                end else if (!r_neg) begin
                    r_speed <= sat_pos ? {1'b0, {(POS_W-1){1'b1}}} : r_dvd[POS_W-1:0];
                    r_clip  <= sat_pos;
                end else begin
                    r_speed <= sat_neg ? {1'b1, {(POS_W-1){1'b0}}}
                                       : (~r_dvd[POS_W-1:0] + 1'b1);
                    r_clip  <= sat_neg;
                end
            end
        end
    end

    // Operand and divider registers carry no control meaning and need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_diff    <= r_pulse - r_last;
            r_elapsed <= i_elapsed_us[EFF_TIME_W-1:0];
        end
        if (i_cmd.mul) begin
            r_neg <= r_diff[POS_W-1];
            r_dvd <= PROD_W'(mag) * PROD_W'(US_PER_MIN);
            r_den <= DEN_W'(r_ppr) * DEN_W'(r_elapsed);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_dvd <= {r_dvd[PROD_W-2:0], fits};
        end
    end

    assign o_sts.denom_zero  = (r_den == '0);
    assign o_position        = r_pulse;
    assign o_speed_rpm       = r_speed;
    assign o_speed_saturated = r_clip;

endmodule

// File: sv/qps_ctrl.sv
// Controller: sequences one item at a time and owns the result valid flag.
// Depends on qps_pkg; commands qps_datapath through t_dp_cmd.
module qps_ctrl import qps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_op     i_op,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             out_free;
    logic             last_step;
    logic             set_valid;

    // The result slot is free when empty or being taken at this edge.
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_step = (r_cnt == CNT_W'(PROD_W - 1));

    assign o_in_ready      = (r_state == S_IDLE) && out_free;
    assign o_cmd.accept    = i_in_valid && o_in_ready;
    assign o_cmd.mul       = (r_state == S_MUL);
    assign o_cmd.div_step  = (r_state == S_DIV) && !i_sts.denom_zero;
    assign o_cmd.finish    = (r_state == S_DONE) && out_free;
    assign o_out_valid     = r_out_valid;

    // A new result appears after an edge or position-reset item or after the speed write-back.
    assign set_valid = (o_cmd.accept && (i_op != OP_SPEED)) || o_cmd.finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (set_valid) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.accept && (i_op == OP_SPEED)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.denom_zero || last_step) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: sv/quadrature_position_and_speed.sv
// Top level of the quadrature position and speed block.
// Depends on qps_pkg, qps_ctrl and qps_datapath.
//
//  Channel  Ports            Carries
//  input    s_axis_*         operation (tuser), level_a, level_b, elapsed_us (tdata)
//  output   m_axis_*         position, speed_rpm, speed_saturated (tdata)
//  config   *_cfg_*          pulses_per_rev
//
// Edge and position-reset items finish when accepted; their result is valid the next cycle.
// A speed update runs an operand step, a multiply step, one bit-serial divider step per
// bit of the 58-bit dividend (a single pass with no step instead when the divisor is zero),
// and a write-back step, which waits while an unread result occupies the slot.
// Reset is synchronous and active low; it clears counts and speed and sets
// pulses per revolution to 20.
// Input is refused while a speed update runs or while an unread result blocks the slot.
module quadrature_position_and_speed import qps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // level_a, level_b, elapsed_us[23:0], zero pad
    input  logic [1:0]            s_axis_tuser,  // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [71:0]           m_axis_tdata,  // position, speed_rpm, speed_saturated, pad
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [PPR_W-1:0]      i_cfg_data
);

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    t_op              op;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] speed_rpm;
    logic             speed_saturated;

    assign op          = t_op'(s_axis_tuser);
    assign o_cfg_ready = 1'b1;

    qps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (op),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    qps_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_op              (op),
        .i_level_a         (s_axis_tdata[0]),
        .i_level_b         (s_axis_tdata[1]),
        .i_elapsed_us      (s_axis_tdata[ELAPSED_W+1:2]),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_position        (position),
        .o_speed_rpm       (speed_rpm),
        .o_speed_saturated (speed_saturated)
    );

    assign m_axis_tdata = {7'b0, speed_saturated, speed_rpm, position};

`ifndef SYNTHESIS
    // A new item never changes state that an unread result still shows.
    a_accept_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |-> (!m_axis_tvalid || m_axis_tready))
        else $error("item accepted while result slot occupied");

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("speed written while result slot occupied");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("speed update produced no result");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.mul || cmd.div_step) |-> !s_axis_tready)
        else $error("input ready during speed computation");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for quadrature_position_and_speed: encoder edges, speed updates
// and position resets go in on a stream, and each result is checked against a local model.
// Depends on qps_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
    import qps_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE      = 4;
    localparam int PRINT_CAP   = 40;

    typedef struct {
        bit         is_cfg;
        bit [15:0]  cfg_val;
        t_op        op;
        bit         lvl_a;
        bit         lvl_b;
        bit [23:0]  elapsed;
    } t_enc_item;

    typedef struct {
        bit [31:0]  position;
        bit [31:0]  speed_rpm;
        bit         saturated;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // level_a, level_b, elapsed_us[23:0], zero pad
    logic [1:0]  s_axis_tuser = '0;    // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;         // position, speed_rpm, speed_saturated, pad
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [PPR_W-1:0] i_cfg_data = '0;

    // Model state of the encoder.
    bit [31:0]   pulse_cnt;
    bit [31:0]   cnt_at_update;
    bit [31:0]   speed_now;
    bit          speed_clip;
    bit [15:0]   ppr_now = PPR_RESET;

    t_enc_item   pending_items[$];
    t_reading    expected_readings[$];
    int          n_built;
    bit [1:0]    gray_idx;
    bit          in_fire;
    bit          cfg_fire;
    int          items_in;
    int          err_count;
    int          cycle_count;
    int          quiet;
    int          tx_gap;
    int          tx_steady;
    int          rx_stall;
    int          rx_steady;
    int          press_left;
    int          next_press = 300;

    quadrature_position_and_speed DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_reading advance_encoder(t_enc_item it);
        t_reading   res;
        bit [31:0]  diff;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned quo;
        case (it.op)
            OP_EDGE_A: begin
                pulse_cnt = (it.lvl_a == it.lvl_b) ? pulse_cnt + 32'd1 : pulse_cnt - 32'd1;
            end
            OP_EDGE_B: begin
                pulse_cnt = (it.lvl_a != it.lvl_b) ? pulse_cnt + 32'd1 : pulse_cnt - 32'd1;
            end
            OP_SPEED: begin
                diff = pulse_cnt - cnt_at_update;
                den = 64'(ppr_now) * 64'(it.elapsed[EFF_TIME_W-1:0]);
                cnt_at_update = pulse_cnt;
                if (den == 0) begin
                    speed_now = '0;
                    speed_clip = 1'b0;
                end else begin
                    // Work on the magnitude; the most negative difference keeps its own bits.
                    mag = {32'd0, diff[31] ? (~diff + 32'd1) : diff};
                    quo = (mag * 64'd60000000) / den;
                    if (!diff[31]) begin
                        speed_clip = quo > 64'h7FFF_FFFF;
                        speed_now = speed_clip ? 32'h7FFF_FFFF : quo[31:0];
                    end else begin
                        speed_clip = quo > 64'h8000_0000;
                        speed_now = speed_clip ? 32'h8000_0000 : -quo[31:0];
                    end
                end
            end
            OP_ZERO: begin
                pulse_cnt = '0;
                cnt_at_update = '0;
            end
        endcase
        res.position = pulse_cnt;
        res.speed_rpm = speed_now;
        res.saturated = speed_clip;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic void push_item(t_op op, bit a, bit b, bit [23:0] el);
        t_enc_item it;
        it.is_cfg = 1'b0;
        it.cfg_val = '0;
        it.op = op;
        it.lvl_a = a;
        it.lvl_b = b;
        it.elapsed = el;
        pending_items.push_back(it);
        n_built++;
    endfunction

    function automatic void push_cfg(bit [15:0] val);
        t_enc_item it;
        it.is_cfg = 1'b1;
        it.cfg_val = val;
        it.op = OP_EDGE_A;
        it.lvl_a = 1'b0;
        it.lvl_b = 1'b0;
        it.elapsed = '0;
        pending_items.push_back(it);
    endfunction

    // One legal quadrature step; Gray order of (A, B) is 00, 10, 11, 01.
    function automatic void step_shaft(bit fwd);
        bit [1:0] nxt;
        bit       chan_a;
        chan_a = fwd ? (gray_idx[0] == 1'b0) : (gray_idx[0] == 1'b1);
        nxt = fwd ? gray_idx + 2'd1 : gray_idx - 2'd1;
        gray_idx = nxt;
        push_item(chan_a ? OP_EDGE_A : OP_EDGE_B, nxt == 2'd1 || nxt == 2'd2, nxt[1],
                  24'($urandom));
    endfunction

    function automatic bit [23:0] pick_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 40)
            return 24'($urandom_range(1, 20));
        if (r < 75)
            return 24'($urandom_range(1, 100000));
        return 24'($urandom);
    endfunction

    // Mostly runs of clean edges closed by a speed update, with some noise and resets.
    function automatic void shaft_phase(int n);
        int target;
        int len;
        int r;
        bit fwd;
        target = n_built + n;
        while (n_built < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                push_item(t_op'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                          24'($urandom));
            end else if (r < 11) begin
                push_item(OP_ZERO, 1'($urandom), 1'($urandom), 24'($urandom));
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 20);
                fwd = 1'($urandom);
                repeat (len) begin
                    if ($urandom_range(0, 19) == 0)
                        fwd = !fwd;
                    step_shaft(fwd);
                end
                push_item(OP_SPEED, 1'($urandom), 1'($urandom), pick_elapsed());
            end
        end
    endfunction

    function automatic int pick_gap(inout int steady);
        int r;
        if (steady > 0) begin
            steady--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            steady = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Sender: items and register writes leave the pending queue in order.
    always @(negedge i_clk) begin : drive_proc
        logic      nv_in;
        logic      nv_cfg;
        t_enc_item it;
        nv_in = s_axis_tvalid;
        nv_cfg = i_cfg_valid;
        if (in_fire)
            nv_in = 1'b0;
        if (cfg_fire)
            nv_cfg = 1'b0;
        in_fire = 1'b0;
        cfg_fire = 1'b0;
        quiet = (expected_readings.size() == 0) ? quiet + 1 : 0;
        if (i_rst_n && !nv_in && !nv_cfg && pending_items.size() != 0) begin
            if (pending_items[0].is_cfg) begin
                // The register only changes once every result has been read out.
                if (quiet >= SETTLE) begin
                    it = pending_items.pop_front();
                    i_cfg_data <= it.cfg_val;
                    nv_cfg = 1'b1;
                end
            end else if (tx_gap > 0) begin
                tx_gap--;
            end else begin
                it = pending_items.pop_front();
                s_axis_tuser <= it.op;
                s_axis_tdata <= {6'd0, it.elapsed, it.lvl_b, it.lvl_a};
                nv_in = 1'b1;
                tx_gap = (press_left > 0) ? 0 : pick_gap(tx_steady);
            end
        end
        s_axis_tvalid <= nv_in;
        i_cfg_valid <= nv_cfg;
    end

    // Receiver: random stalls, plus long hold-offs that back the block up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (items_in >= next_press) begin
            press_left = 150;
            next_press += 350;
            m_axis_tready <= 1'b0;
        end else if (press_left > 0) begin
            press_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_stall = pick_gap(rx_steady);
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_enc_item it;
        t_reading  want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                ppr_now = i_cfg_data;
                cfg_fire = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                it.is_cfg = 1'b0;
                it.cfg_val = '0;
                it.op = t_op'(s_axis_tuser);
                it.lvl_a = s_axis_tdata[0];
                it.lvl_b = s_axis_tdata[1];
                it.elapsed = s_axis_tdata[25:2];
                expected_readings.push_back(advance_encoder(it));
                items_in++;
                in_fire = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("result with nothing expected, position",
                                    $signed(m_axis_tdata[31:0]), 0);
                end else begin
                    want = expected_readings.pop_front();
                    if (m_axis_tdata[31:0] !== want.position)
                        report_mismatch("position", $signed(m_axis_tdata[31:0]),
                                        $signed(want.position));
                    if (m_axis_tdata[63:32] !== want.speed_rpm)
                        report_mismatch("speed_rpm", $signed(m_axis_tdata[63:32]),
                                        $signed(want.speed_rpm));
                    if (m_axis_tdata[64] !== want.saturated)
                        report_mismatch("speed_saturated", m_axis_tdata[64], want.saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        // Directed part at the reset value of pulses per revolution.
        push_item(OP_EDGE_A, 1'b0, 1'b0, 24'hFFFFFF);
        push_item(OP_EDGE_A, 1'b1, 1'b0, 24'h000000);
        push_item(OP_EDGE_A, 1'b1, 1'b1, 24'h555555);
        push_item(OP_EDGE_A, 1'b0, 1'b1, 24'hAAAAAA);
        push_item(OP_EDGE_B, 1'b0, 1'b0, 24'h000001);
        push_item(OP_EDGE_B, 1'b1, 1'b0, 24'h800000);
        push_item(OP_EDGE_B, 1'b1, 1'b1, 24'h7FFFFF);
        push_item(OP_EDGE_B, 1'b0, 1'b1, 24'h123456);
        push_item(OP_SPEED, 1'b1, 1'b1, 24'h000000);
        repeat (3) push_item(OP_EDGE_A, 1'b1, 1'b1, 24'h0);
        push_item(OP_SPEED, 1'b0, 1'b1, 24'h000001);
        repeat (2) push_item(OP_EDGE_B, 1'b0, 1'b0, 24'h0);
        push_item(OP_SPEED, 1'b1, 1'b0, 24'hFFFFFF);
        push_item(OP_ZERO, 1'b1, 1'b1, 24'hFFFFFF);
        // Counting down from zero wraps the position to all ones.
        push_item(OP_EDGE_A, 1'b0, 1'b1, 24'h0);
        push_item(OP_SPEED, 1'b0, 1'b0, 24'h800000);

        // One pulse per revolution and one microsecond clip the speed at both ends.
        push_cfg(16'd1);
        repeat (40) step_shaft(1'b1);
        push_item(OP_SPEED, 1'b0, 1'b0, 24'd1);
        repeat (45) step_shaft(1'b0);
        push_item(OP_SPEED, 1'b1, 1'b1, 24'd1);
        shaft_phase(150);
        push_cfg(16'hFFFF);
        shaft_phase(150);
        // A divisor of zero behaves like zero elapsed time.
        push_cfg(16'd0);
        shaft_phase(100);
        push_cfg(16'($urandom_range(2, 65534)));
        shaft_phase(150);
        push_cfg(PPR_RESET);
        shaft_phase(150);
        push_cfg(16'($urandom_range(2, 200)));
        shaft_phase(150);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_items.size() != 0 || s_axis_tvalid || i_cfg_valid)
            @(posedge i_clk);
        while (expected_readings.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
